>>> rtl/srd_pkg.sv
// Shared types and constants of the screen difference refresh block.
package srd_pkg;

  typedef enum logic [1:0] {
    CMD_CURSOR_OFF = 2'd0,
    CMD_GOTO       = 2'd1,
    CMD_WRITE      = 2'd2,
    CMD_CURSOR_ON  = 2'd3
  } srd_cmd_e;

  typedef enum logic [0:0] {
    CFG_COLUMNS = 1'b0,
    CFG_ROWS    = 1'b1
  } srd_cfg_e;

  localparam logic [7:0] SPACE_CHAR    = 8'h20;
  localparam logic [7:0] RESET_COLUMNS = 8'd80;
  localparam logic [6:0] RESET_ROWS    = 7'd25;

  // Commands produced by one item, in emission order: off, cursor fix, write, on.
  typedef struct packed {
    logic       off;
    logic       pre;
    logic       pre_goto;
    logic       wr;
    logic       on;
    logic [5:0] row;
    logic [6:0] col;
    logic [7:0] pre_char;
    logic [7:0] wr_char;
  } srd_bundle_t;

endpackage

>>> rtl/srd_screen_ram.sv
// Single-port-write, single-port-read screen store with registered read data.
module srd_screen_ram #(
  parameter int unsigned AW = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [2**AW];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/srd_diff_stage.sv
// Compare stage: checks the stored character, tracks the cursor and writes the store back.
module srd_diff_stage #(
  parameter int unsigned RW = 6,
  parameter int unsigned CW = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic [7:0]          char_i,
  input  logic [RW-1:0]       row_i,
  input  logic [CW-1:0]       col_i,
  input  logic                first_i,
  input  logic                last_i,
  output logic                ready_o,
  input  logic [7:0]          rd_data_i,
  input  logic                emit_empty_i,
  output logic                fire_o,
  output logic                wr_en_o,
  output logic [RW+CW-1:0]    wr_addr_o,
  output logic [7:0]          wr_data_o,
  output srd_pkg::srd_bundle_t bundle_o
);
  import srd_pkg::*;

  logic          valid_q, valid_d;
  logic [7:0]    char_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic          first_q;
  logic          last_q;
  logic          fwd_q;
  logic [7:0]    fwd_char_q;

  logic [7:0]    prev_char_q, prev_char_d;
  logic          known_q, known_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [CW:0]   cur_col_q, cur_col_d;

  logic          fire;
  logic          fwd_d;
  logic [7:0]    stored;
  logic          known;
  logic          diff;
  logic          at_pos;
  logic          adj;
  logic [CW:0]   col_ext;

  assign fire    = valid_q && emit_empty_i;
  assign fire_o  = fire;
  assign ready_o = !valid_q || fire;
  assign fwd_d   = fire && ({row_q, col_q} == {row_i, col_i});
  assign stored  = fwd_q ? fwd_char_q : rd_data_i;
  assign col_ext = {1'b0, col_q};

  always_comb begin
    known  = first_q ? 1'b0 : known_q;
    diff   = stored != char_q;
    at_pos = known && (cur_row_q == row_q) && (cur_col_q == col_ext);
    adj    = known && (cur_row_q == row_q) && ((cur_col_q + (CW+1)'(1)) == col_ext);

    valid_d     = valid_q;
    prev_char_d = prev_char_q;
    known_d     = known_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    if (fire) begin
      valid_d     = 1'b0;
      prev_char_d = char_q;
      known_d     = known;
      if (diff) begin
        known_d   = 1'b1;
        cur_row_d = row_q;
        cur_col_d = col_ext + (CW+1)'(1);
      end
    end
    if (acc_i) begin
      valid_d = 1'b1;
    end

    bundle_o.off      = first_q;
    bundle_o.pre      = diff && !at_pos;
    bundle_o.pre_goto = !adj;
    bundle_o.wr       = diff;
    bundle_o.on       = last_q;
    bundle_o.row      = 6'(row_q);
    bundle_o.col      = 7'(col_q);
    bundle_o.pre_char = prev_char_q;
    bundle_o.wr_char  = char_q;
  end

  assign wr_en_o   = fire && diff;
  assign wr_addr_o = {row_q, col_q};
  assign wr_data_o = char_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      prev_char_q <= 8'd0;
      known_q     <= 1'b0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
    end else begin
      valid_q     <= valid_d;
      prev_char_q <= prev_char_d;
      known_q     <= known_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      char_q     <= char_i;
      row_q      <= row_i;
      col_q      <= col_i;
      first_q    <= first_i;
      last_q     <= last_i;
      fwd_q      <= fwd_d;
      fwd_char_q <= char_q;
    end
  end

endmodule

>>> rtl/srd_cmd_emit.sv
// Command register that hands out the pending commands of one item, one per transfer.
module srd_cmd_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  srd_pkg::srd_bundle_t bundle_i,
  output logic                 empty_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output srd_pkg::srd_cmd_e    kind_o,
  output logic [5:0]           row_o,
  output logic [6:0]           col_o,
  output logic [7:0]           char_o,
  output logic                 last_o
);
  import srd_pkg::*;

  // Pending bits from low to high: cursor off, cursor fix, write, cursor on.
  logic [3:0] pend_q, pend_d;
  logic       pre_goto_q;
  logic [5:0] row_q;
  logic [6:0] col_q;
  logic [7:0] pre_char_q;
  logic [7:0] wr_char_q;
  logic [3:0] sel;

  assign valid_o = pend_q != 4'd0;
  assign empty_o = !valid_o;

  always_comb begin
    sel    = 4'd0;
    kind_o = CMD_CURSOR_ON;
    row_o  = 6'd0;
    col_o  = 7'd0;
    char_o = 8'd0;
    if (pend_q[0]) begin
      sel    = 4'b0001;
      kind_o = CMD_CURSOR_OFF;
    end else if (pend_q[1]) begin
      sel = 4'b0010;
      if (pre_goto_q) begin
        kind_o = CMD_GOTO;
        row_o  = row_q;
        col_o  = col_q;
      end else begin
        kind_o = CMD_WRITE;
        char_o = pre_char_q;
      end
    end else if (pend_q[2]) begin
      sel    = 4'b0100;
      kind_o = CMD_WRITE;
      char_o = wr_char_q;
    end else if (pend_q[3]) begin
      sel    = 4'b1000;
      kind_o = CMD_CURSOR_ON;
    end
    last_o = (pend_q & ~sel) == 4'd0;

    pend_d = pend_q;
    if (load_i) begin
      pend_d = {bundle_i.on, bundle_i.wr, bundle_i.pre, bundle_i.off};
    end else if (valid_o && ready_i) begin
      pend_d = pend_q & ~sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 4'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pre_goto_q <= bundle_i.pre_goto;
      row_q      <= bundle_i.row;
      col_q      <= bundle_i.col;
      pre_char_q <= bundle_i.pre_char;
      wr_char_q  <= bundle_i.wr_char;
    end
  end

endmodule

>>> rtl/screen_diff_refresh.sv
// Top level of the incremental terminal screen refresh block.
//
//   Channel   Direction  Transfer when                   Carries
//   s_axis    in         s_axis_tvalid & s_axis_tready   next_char
//   m_axis    out        m_axis_tvalid & m_axis_tready   one terminal command
//   cfg       in         cfg_valid_i & cfg_ready_o       screen size registers
//
// The commands of an item go into the command register, which must drain before
// the compare stage moves on; a new item is taken when the compare stage is empty
// or hands its item over. The screen store is read at the input transfer, compared
// when the compare stage fires and written back there, with forwarding for a repeated
// address. After reset a clearing pass fills all MAX_ROWS * 2**ceil(log2(MAX_COLUMNS))
// store entries with spaces while s_axis_tready stays low; cfg is always ready.
module screen_diff_refresh #(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] next_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [5:0] goto_row, [12:6] goto_col, [20:13] out_char
  output logic [1:0]  m_axis_tuser,   // [1:0] cmd_kind
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import srd_pkg::*;

  localparam int unsigned CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned DEPTH = MAX_ROWS << CW;

  logic [7:0]    cols_q;
  logic [6:0]    rows_q;
  logic [RW-1:0] pos_row_q, pos_row_d;
  logic [CW-1:0] pos_col_q, pos_col_d;
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  logic [8:0]    cols_w;
  logic [7:0]    rows_w;
  logic [CW:0]   cols_eff;
  logic [RW:0]   rows_m1;
  logic [CW:0]   col_inc, col_n;
  logic [RW:0]   row_inc, row_n;
  logic          frame_end;
  logic          first;
  logic          acc;

  logic          st_ready;
  logic          st_fire;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [7:0]    st_wdata;
  logic [7:0]    rd_data;
  logic          emit_empty;
  srd_bundle_t   bundle;
  srd_cmd_e      kind;
  logic [5:0]    out_row;
  logic [6:0]    out_col;
  logic [7:0]    out_char;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !clr_q && st_ready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cols_w = {1'b0, cols_q};
    if (cols_w == 9'd0) begin
      cols_w = 9'd1;
    end else if (cols_w > 9'(MAX_COLUMNS)) begin
      cols_w = 9'(MAX_COLUMNS);
    end
    cols_eff = (CW+1)'(cols_w);

    rows_w = {1'b0, rows_q};
    if (rows_w < 8'd2) begin
      rows_w = 8'd2;
    end else if (rows_w > 8'(MAX_ROWS)) begin
      rows_w = 8'(MAX_ROWS);
    end
    rows_m1 = (RW+1)'(rows_w - 8'd1);

    col_inc = {1'b0, pos_col_q} + (CW+1)'(1);
    row_inc = {1'b0, pos_row_q} + (RW+1)'(1);
    if (col_inc >= cols_eff) begin
      col_n = '0;
      row_n = row_inc;
    end else begin
      col_n = col_inc;
      row_n = {1'b0, pos_row_q};
    end
    frame_end = row_n >= rows_m1;
    first     = (pos_row_q == '0) && (pos_col_q == '0);

    pos_row_d = pos_row_q;
    pos_col_d = pos_col_q;
    if (acc) begin
      if (frame_end) begin
        pos_row_d = '0;
        pos_col_d = '0;
      end else begin
        pos_row_d = row_n[RW-1:0];
        pos_col_d = col_n[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= RESET_COLUMNS;
      rows_q     <= RESET_ROWS;
      pos_row_q  <= '0;
      pos_col_q  <= '0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      pos_row_q <= pos_row_d;
      pos_col_q <= pos_col_d;
      if (cfg_valid_i) begin
        case (srd_cfg_e'(cfg_index_i))
          CFG_COLUMNS: cols_q <= cfg_data_i;
          CFG_ROWS:    rows_q <= cfg_data_i[6:0];
          default: begin
          end
        endcase
      end
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  assign ram_we    = clr_q || st_we;
  assign ram_waddr = clr_q ? clr_addr_q : st_waddr;
  assign ram_wdata = clr_q ? SPACE_CHAR : st_wdata;

  srd_screen_ram #(
    .AW(AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (acc),
    .raddr_i({pos_row_q, pos_col_q}),
    .rdata_o(rd_data)
  );

  srd_diff_stage #(
    .RW(RW),
    .CW(CW)
  ) u_diff (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .char_i      (s_axis_tdata),
    .row_i       (pos_row_q),
    .col_i       (pos_col_q),
    .first_i     (first),
    .last_i      (frame_end),
    .ready_o     (st_ready),
    .rd_data_i   (rd_data),
    .emit_empty_i(emit_empty),
    .fire_o      (st_fire),
    .wr_en_o     (st_we),
    .wr_addr_o   (st_waddr),
    .wr_data_o   (st_wdata),
    .bundle_o    (bundle)
  );

  srd_cmd_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (st_fire),
    .bundle_i(bundle),
    .empty_o (emit_empty),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .kind_o  (kind),
    .row_o   (out_row),
    .col_o   (out_col),
    .char_o  (out_char),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tdata = {3'd0, out_char, out_col, out_row};

endmodule

>>> dv/screen_diff_refresh_chk.sv
// Checker that predicts and compares the terminal commands of the screen refresh block.
module screen_diff_refresh_chk #(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,
  input  logic [1:0]  m_tuser_i,
  input  logic        m_tlast_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import srd_pkg::*;

  typedef struct packed {
    srd_cmd_e   kind;
    logic [5:0] row;
    logic [6:0] col;
    logic [7:0] ch;
    logic       last;
  } term_cmd_t;

  localparam int unsigned STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;

  logic [7:0] shown_screen [STORE_DEPTH];
  logic [5:0] pos_row;
  logic [6:0] pos_col;
  logic [6:0] cur_row;
  logic [7:0] cur_col;
  logic [7:0] prev_char;
  logic [7:0] columns_reg;
  logic [6:0] rows_reg;
  term_cmd_t  expected_cmds [$];
  int         errors;

  function automatic term_cmd_t make_cmd(srd_cmd_e kind, int row, int col, logic [7:0] ch);
    term_cmd_t c;
    c.kind = kind;
    c.row  = 6'(row);
    c.col  = 7'(col);
    c.ch   = ch;
    c.last = 1'b0;
    return c;
  endfunction

  task automatic refresh_position(input logic [7:0] ch);
    term_cmd_t cmds [$];
    term_cmd_t c;
    int        cols;
    int        rows;
    int        row;
    int        col;
    int        addr;
    cols = (columns_reg == 0) ? 1 : (columns_reg > MAX_COLUMNS) ? MAX_COLUMNS : columns_reg;
    rows = (rows_reg < 2) ? 2 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
    row  = pos_row;
    col  = pos_col;
    addr = (row * MAX_COLUMNS + col) % STORE_DEPTH;

    // Every frame starts with the cursor position unknown.
    if (row == 0 && col == 0) begin
      cur_row = '1;
      cur_col = '1;
      cmds.push_back(make_cmd(CMD_CURSOR_OFF, 0, 0, 8'h00));
    end

    if (shown_screen[addr] != ch) begin
      if (int'(cur_row) != row || int'(cur_col) != col) begin
        if (int'(cur_row) == row && int'(cur_col) + 1 == col) begin
          cmds.push_back(make_cmd(CMD_WRITE, 0, 0, prev_char));
          cur_col = cur_col + 8'd1;
        end else begin
          cmds.push_back(make_cmd(CMD_GOTO, row, col, 8'h00));
          cur_row = 7'(row);
          cur_col = 8'(col);
        end
      end
      shown_screen[addr] = ch;
      cmds.push_back(make_cmd(CMD_WRITE, 0, 0, ch));
      cur_col = cur_col + 8'd1;
    end

    prev_char = ch;
    col++;
    if (col >= cols) begin
      col = 0;
      row++;
    end
    if (row >= rows - 1) begin
      cmds.push_back(make_cmd(CMD_CURSOR_ON, 0, 0, 8'h00));
      row = 0;
      col = 0;
    end
    pos_row = 6'(row);
    pos_col = 7'(col);

    foreach (cmds[i]) begin
      c = cmds[i];
      c.last = (i == cmds.size() - 1);
      expected_cmds.push_back(c);
    end
  endtask

  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_cmd();
    term_cmd_t exp_c;
    if (expected_cmds.size() == 0) begin
      $error("command transfer with nothing expected: kind %0d tdata %h",
             m_tuser_i, m_tdata_i);
      errors++;
    end else begin
      exp_c = expected_cmds.pop_front();
      compare_field("cmd_kind", exp_c.kind, m_tuser_i);
      compare_field("goto_row", exp_c.row, m_tdata_i[5:0]);
      compare_field("goto_col", exp_c.col, m_tdata_i[12:6]);
      compare_field("out_char", exp_c.ch, m_tdata_i[20:13]);
      compare_field("tdata_pad", 0, m_tdata_i[23:21]);
      compare_field("last_of_run", exp_c.last, m_tlast_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (shown_screen[i]) shown_screen[i] = SPACE_CHAR;
      pos_row     = '0;
      pos_col     = '0;
      cur_row     = '1;
      cur_col     = '1;
      prev_char   = '0;
      columns_reg = RESET_COLUMNS;
      rows_reg    = RESET_ROWS;
      expected_cmds.delete();
      errors      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (srd_cfg_e'(cfg_index_i))
          CFG_COLUMNS: columns_reg = cfg_data_i;
          CFG_ROWS:    rows_reg = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) check_cmd();
      if (s_tvalid_i && s_tready_i) refresh_position(s_tdata_i);
      fail_count_o <= errors;
      pending_o    <= expected_cmds.size();
    end
  end

endmodule

>>> dv/screen_diff_refresh_tb.sv
// Testbench top that drives the screen refresh block and reports the verdict.
module screen_diff_refresh_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srd_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 250;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          burst_left;
  int          gap;
  logic        hold_off_req;

  logic [7:0] frame_a [6] = '{8'h20, 8'h41, 8'h42, 8'h00, 8'h20, 8'hFF};

  screen_diff_refresh dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  screen_diff_refresh_chk chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .m_tlast_i    (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Command side: stretches of steady, random and sparse acceptance, plus one long hold-off.
  initial begin
    int   mode;
    int   len;
    logic held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req && !held) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        held = 1'b1;
      end
      mode = $urandom_range(0, 2);
      len  = $urandom_range(5, 60);
      repeat (len) begin
        @(negedge clk_i);
        case (mode)
          0:       m_axis_tready = 1'b1;
          1:       m_axis_tready = 1'($urandom_range(0, 1));
          default: m_axis_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_char(input logic [7:0] ch);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = ch;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input srd_cfg_e index, input logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SPACE_CHAR;
      4, 5:       return 8'h41;
      6:          return 8'h42;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int          sent;
    int          phase_len;
    logic [7:0]  cols;
    logic [6:0]  rows;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_COLUMNS;
    cfg_data_i    = '0;
    hold_off_req  = 1'b0;
    burst_left    = 0;
    rst_ni        = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Two small frames: goto, plain write, resend of the previous character,
    // unchanged positions, then the same frame again with nothing to redraw.
    write_reg(CFG_COLUMNS, 8'd3);
    write_reg(CFG_ROWS, 8'd3);
    repeat (2) foreach (frame_a[i]) send_char(frame_a[i]);
    send_char(8'h5A);
    wait_idle();

    // Out-of-range sizes give a one-position frame: every command of an item at once.
    write_reg(CFG_COLUMNS, 8'd0);
    write_reg(CFG_ROWS, 8'd0);
    send_char(8'h51);
    send_char(8'h52);
    wait_idle();

    // Largest sizes, then a shrink in the middle of the frame.
    write_reg(CFG_COLUMNS, 8'd255);
    write_reg(CFG_ROWS, 8'd127);
    repeat (3) send_char(8'h78);
    wait_idle();
    write_reg(CFG_COLUMNS, 8'd2);
    write_reg(CFG_ROWS, 8'd2);
    send_char(8'h80);
    wait_idle();

    sent = 0;
    hold_off_req = 1'b1;
    phase_len = 40;
    while (sent < RANDOM_ITEMS) begin
      repeat (phase_len) begin
        send_char(pick_char());
        sent++;
      end
      wait_idle();
      if ($urandom_range(0, 3) != 0) begin
        cols = 8'($urandom_range(1, 8));
      end else begin
        case ($urandom_range(0, 3))
          0:       cols = 8'd0;
          1:       cols = 8'd128;
          2:       cols = 8'($urandom_range(129, 255));
          default: cols = 8'($urandom_range(9, 127));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        rows = 7'($urandom_range(2, 5));
      end else begin
        case ($urandom_range(0, 3))
          0:       rows = 7'($urandom_range(0, 1));
          1:       rows = 7'd64;
          2:       rows = 7'($urandom_range(65, 127));
          default: rows = 7'($urandom_range(6, 63));
        endcase
      end
      case ($urandom_range(0, 2))
        0: begin
          write_reg(CFG_COLUMNS, cols);
          write_reg(CFG_ROWS, {1'($urandom_range(0, 1)), rows});
        end
        1: write_reg(CFG_COLUMNS, cols);
        default: write_reg(CFG_ROWS, {1'($urandom_range(0, 1)), rows});
      endcase
      phase_len = $urandom_range(10, 40);
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/srd_pkg.sv
rtl/srd_screen_ram.sv
rtl/srd_diff_stage.sv
rtl/srd_cmd_emit.sv
rtl/screen_diff_refresh.sv
dv/screen_diff_refresh_chk.sv
dv/screen_diff_refresh_tb.sv
